/* rtl/assert_macros.svh */
// Assertion macros shared by the hash collision counter RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPL(label, clk, rst, ante, cons)

`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* rtl/hcc_pkg.sv */
// Package: widths, register codes, types and helpers of the hash collision counter
`timescale 1ns / 1ps

package hcc_pkg;

  localparam int KEY_W           = 32;
  localparam int SLOT_W          = 9;
  localparam int COUNT_W         = 16;
  localparam int SHIFT_W         = 4;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 16;
  localparam int EPOCH_W         = 8;
  localparam int TABLE_DEPTH_DEF = 512;

  localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
  localparam logic [EPOCH_W-1:0] EPOCH_MAX   = '1;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [SHIFT_W-1:0] TBITS_MIN   = SHIFT_W'(1);
  localparam logic [SHIFT_W-1:0] TBITS_MAX   = SHIFT_W'(SLOT_W);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_XOR    = 3'd0,
    REG_SHIFT1 = 3'd1,
    REG_LSHIFT = 3'd2,
    REG_SHIFT2 = 3'd3,
    REG_MULT   = 3'd4,
    REG_SHIFT3 = 3'd5,
    REG_TBITS  = 3'd6
  } cfg_reg_t;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic [15:0]        xor_constant;
    logic [SHIFT_W-1:0] first_right_shift;
    logic [SHIFT_W-1:0] left_shift_add;
    logic [SHIFT_W-1:0] second_right_shift;
    logic [15:0]        multiplier;
    logic [SHIFT_W-1:0] final_right_shift;
    logic [SHIFT_W-1:0] table_bits;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic              last;
    logic [SLOT_W-1:0] slot;
  } hash_out_t;

  function automatic logic [SLOT_W-1:0] slot_mask(input logic [SHIFT_W-1:0] tbits);
    logic [SHIFT_W-1:0] b;
    b = tbits;
    if (b < TBITS_MIN) b = TBITS_MIN;
    if (b > TBITS_MAX) b = TBITS_MAX;
    return SLOT_W'((10'd1 << b) - 10'd1);
  endfunction

endpackage

/* rtl/hcc_ifs.sv */
// Channel interfaces: key input, result output and register write
`timescale 1ns / 1ps

interface hcc_key_if
  import hcc_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key;
  logic             last_key;

  modport source (output valid, key, last_key, input ready);
  modport sink   (input valid, key, last_key, output ready);
endinterface

interface hcc_result_if
  import hcc_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [SLOT_W-1:0]  slot;
  logic               collided;
  logic [COUNT_W-1:0] collision_count;
  logic               set_done;

  modport source (output valid, slot, collided, collision_count, set_done, input ready);
  modport sink   (input valid, slot, collided, collision_count, set_done, output ready);
endinterface

interface hcc_cfg_if
  import hcc_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/hcc_hash.sv */
// Two-stage key mixing pipeline and slot mask
`timescale 1ns / 1ps

module hcc_hash
  import hcc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic             load,
  input  logic [KEY_W-1:0] key,
  input  logic             last_key,
  input  cfg_t             cfg,
  output hash_out_t        hout
);

  logic             v1;
  logic             l1;
  logic [KEY_W-1:0] h1;
  logic             v2;
  logic             l2;
  logic [KEY_W-1:0] h2;

  logic [KEY_W-1:0] x1;
  logic [KEY_W-1:0] x2;
  logic [KEY_W-1:0] x3;
  logic [KEY_W-1:0] x5;

  assign x1 = (key ^ KEY_W'(cfg.xor_constant)) ^ (key >> cfg.first_right_shift);
  assign x2 = x1 + (x1 << cfg.left_shift_add);
  assign x3 = x2 ^ (x2 >> cfg.second_right_shift);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (advance) begin
      v1 <= load;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      h1 <= x3;
      l1 <= last_key;
      h2 <= h1 * KEY_W'(cfg.multiplier);
      l2 <= l1;
    end
  end

  assign x5 = h2 ^ (h2 >> cfg.final_right_shift);

  assign hout.valid = v2;
  assign hout.last  = l2;
  assign hout.slot  = x5[SLOT_W-1:0] & slot_mask(cfg.table_bits);

endmodule

/* rtl/hash_collision_counter.sv */
// Top level: configurable key hash with occupancy bitmap and collision count
`timescale 1ns / 1ps
//
// Keys arrive on the keys channel (key, last_key); one result per key leaves
// on the results channel (slot, collided, collision_count, set_done). Hash
// coefficients and table_bits are written through the cfg channel, which is
// always ready; write it only while no key is in flight.
// An accepted key passes the hash pipeline, the bitmap read stage and the
// output register. Throughput: one key per cycle; the occupancy bitmap is a
// one-read, one-write memory with a registered read, and a key that hits the
// slot of the key just ahead of it is caught by forwarding.
// Entries carry a set tag (epoch) instead of being cleared after every set.
// After reset, and after every 255 completed sets, a clearing pass writes
// all TABLE_DEPTH entries, one per cycle; keys.ready is low during it.
// When results.ready is low while a result waits, the whole pipeline holds
// and keys.ready drops; that result waits in the output register unchanged.

`include "assert_macros.svh"

module hash_collision_counter
  import hcc_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input logic           clk,
  input logic           rst,
  hcc_key_if.sink       keys,
  hcc_result_if.source  results,
  hcc_cfg_if.sink       cfg
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);

  cfg_t cfg_q;

  state_t           state;
  state_t           state_next;
  logic [IDX_W-1:0] clr_idx;
  logic [IDX_W-1:0] clr_idx_next;

  logic [EPOCH_W-1:0] epoch;
  logic [EPOCH_W-1:0] in_epoch;
  logic               hold;

  logic      advance;
  logic      load;
  hash_out_t hout;

  logic [IDX_W-1:0] idx_c;
  logic             fwd_c;

  logic               v3;
  logic               s3_last;
  logic [SLOT_W-1:0]  s3_slot;
  logic [IDX_W-1:0]   s3_idx;
  logic [EPOCH_W-1:0] rdata;
  logic               fwd;

  logic               hit;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_new;

  logic               ov;
  logic [SLOT_W-1:0]  o_slot;
  logic               o_coll;
  logic [COUNT_W-1:0] o_count;
  logic               o_done;

  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [EPOCH_W-1:0] mem_wdata;
  logic [EPOCH_W-1:0] occ_mem [TABLE_DEPTH];

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.xor_constant       <= '0;
      cfg_q.first_right_shift  <= '0;
      cfg_q.left_shift_add     <= '0;
      cfg_q.second_right_shift <= '0;
      cfg_q.multiplier         <= 16'd1;
      cfg_q.final_right_shift  <= '0;
      cfg_q.table_bits         <= SHIFT_W'(8);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_XOR:    cfg_q.xor_constant       <= cfg.data;
        REG_SHIFT1: cfg_q.first_right_shift  <= cfg.data[SHIFT_W-1:0];
        REG_LSHIFT: cfg_q.left_shift_add     <= cfg.data[SHIFT_W-1:0];
        REG_SHIFT2: cfg_q.second_right_shift <= cfg.data[SHIFT_W-1:0];
        REG_MULT:   cfg_q.multiplier         <= cfg.data;
        REG_SHIFT3: cfg_q.final_right_shift  <= cfg.data[SHIFT_W-1:0];
        REG_TBITS:  cfg_q.table_bits         <= cfg.data[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign advance    = !ov || results.ready;
  assign keys.ready = advance && (state == ST_RUN) && !hold;
  assign load       = keys.valid && keys.ready;

  hcc_hash u_hash (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .load     (load),
    .key      (keys.key),
    .last_key (keys.last_key),
    .cfg      (cfg_q),
    .hout     (hout)
  );

  // bitmap index: slot folded onto the table depth
  if (TABLE_DEPTH >= (1 << SLOT_W)) begin : g_wide
    assign idx_c = IDX_W'(hout.slot);
  end else begin : g_fold
    localparam int RECIP_SH = 2 * SLOT_W;
    localparam int RECIP    = (1 << RECIP_SH) / TABLE_DEPTH + 1;
    localparam int PROD_W   = SLOT_W + RECIP_SH;
    logic [PROD_W-1:0] prod;
    logic [SLOT_W-1:0] quot;
    logic [SLOT_W-1:0] dsub;
    assign prod  = PROD_W'(hout.slot) * PROD_W'(RECIP);
    assign quot  = prod[PROD_W-1:RECIP_SH];
    assign dsub  = SLOT_W'(quot * SLOT_W'(TABLE_DEPTH));
    assign idx_c = IDX_W'(hout.slot - dsub);
  end

  // same entry written by the key ahead, within the same set
  assign fwd_c = v3 && !s3_last && (s3_idx == idx_c);

  // read-modify-write stage
  assign hit       = (rdata == epoch) || fwd;
  assign count_new = (hit && (count != COUNT_MAX)) ? count + COUNT_W'(1) : count;

  assign mem_we    = (state == ST_CLEAR) || (advance && v3);
  assign mem_waddr = (state == ST_CLEAR) ? clr_idx : s3_idx;
  assign mem_wdata = (state == ST_CLEAR) ? '0 : epoch;

  always_ff @(posedge clk) begin
    if (mem_we) occ_mem[mem_waddr] <= mem_wdata;
    if (advance) rdata <= occ_mem[idx_c];
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_last <= hout.last;
      s3_slot <= hout.slot;
      s3_idx  <= idx_c;
      fwd     <= fwd_c;
      o_slot  <= s3_slot;
      o_coll  <= hit;
      o_count <= count_new;
      o_done  <= s3_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3    <= 1'b0;
      ov    <= 1'b0;
      count <= '0;
    end else if (advance) begin
      v3 <= hout.valid;
      ov <= v3;
      if (v3) count <= s3_last ? '0 : count_new;
    end
  end

  // set tags
  always_ff @(posedge clk) begin
    if (rst) begin
      epoch    <= EPOCH_FIRST;
      in_epoch <= EPOCH_FIRST;
      hold     <= 1'b0;
    end else begin
      if (state == ST_CLEAR && clr_idx == IDX_LAST) begin
        epoch    <= EPOCH_FIRST;
        in_epoch <= EPOCH_FIRST;
        hold     <= 1'b0;
      end else begin
        if (advance && v3 && s3_last) epoch <= epoch + EPOCH_W'(1);
        if (load && keys.last_key) begin
          if (in_epoch == EPOCH_MAX) hold <= 1'b1;
          else in_epoch <= in_epoch + EPOCH_W'(1);
        end
      end
    end
  end

  // clearing sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_idx <= '0;
    end else begin
      state   <= state_next;
      clr_idx <= clr_idx_next;
    end
  end

  always_comb begin
    state_next   = state;
    clr_idx_next = clr_idx;
    unique case (state)
      ST_CLEAR: begin
        clr_idx_next = clr_idx + IDX_W'(1);
        if (clr_idx == IDX_LAST) begin
          state_next   = ST_RUN;
          clr_idx_next = '0;
        end
      end
      ST_RUN: begin
        if (advance && v3 && s3_last && epoch == EPOCH_MAX) state_next = ST_CLEAR;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  assign results.valid           = ov;
  assign results.slot            = o_slot;
  assign results.collided        = o_coll;
  assign results.collision_count = o_count;
  assign results.set_done        = o_done;

  `ASSERT_IMPL(a_clear_blocks_keys, clk, rst, state == ST_CLEAR, !keys.ready)
  `ASSERT_IMPL(a_clear_pipe_empty, clk, rst, state == ST_CLEAR, !v3 && !hout.valid)
  `ASSERT_IMPL(a_coll_count_nonzero, clk, rst, results.valid && results.collided, results.collision_count != '0)
  `ASSERT_NEXT(a_count_saturates, clk, rst, count == COUNT_MAX && !(advance && v3 && s3_last), count == COUNT_MAX)

endmodule
